>>> design/ssp_pkg.sv
// types and constants shared by the seven-bit sysex packer
`timescale 1ns / 1ps

package ssp_pkg;

    localparam int MAX_RESULTS = 12;
    localparam int GROUP_LEN   = 7;
    localparam int TAIL_LEN    = 5;

    localparam logic [7:0]  SYSEX_END  = 8'hF7;
    localparam logic [15:0] LEN_OFFSET = 16'd5;

    typedef enum logic [2:0] {
        CMD_DATA       = 3'd0,
        CMD_FLUSH      = 3'd1,
        CMD_START7     = 3'd2,
        CMD_STOP7      = 3'd3,
        CMD_CSUM_START = 3'd4,
        CMD_CSUM_END   = 3'd5,
        CMD_RESET      = 3'd6
    } t_cmd;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] bytes_emitted;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [6:0]                  hdr;
        logic [GROUP_LEN-1:0][6:0]   store;
        logic [2:0]                  fill;
        logic                        seven;
        logic                        csum_on;
        logic [15:0]                 sum;
        logic [15:0]                 count;
    } t_state;

    typedef struct packed {
        logic [3:0]                  n;
        logic [MAX_RESULTS-1:0][7:0] bytes;
        t_state                      next;
    } t_step;

endpackage

>>> design/ssp_step_logic.sv
// per-command encoder: burst of output bytes and next packer state
`timescale 1ns / 1ps

module ssp_step_logic
    import ssp_pkg::*;
(
    input  t_in    i_item,
    input  t_state i_state,
    output t_step  o_step
);

    t_cmd              cmd;
    logic [7:0]        b;
    logic [3:0]        flush_n;
    logic [7:0][7:0]   grp;
    logic [7:0][7:0]   grp_full;
    logic [6:0]        hdr_new;
    logic [15:0]       flush_sum;
    logic [15:0]       full_sum;
    logic [15:0]       len;
    logic [TAIL_LEN-1:0][7:0] tail;
    logic [3:0]        j;

    assign cmd = t_cmd'(i_item.command);
    assign b   = i_item.data_byte;
    assign len = i_state.count - LEN_OFFSET;

    always_comb begin
        flush_n = (i_state.fill != 3'd0) ? ({1'b0, i_state.fill} + 4'd1) : 4'd0;
        hdr_new = ((i_state.fill == 3'd0) ? 7'd0 : i_state.hdr)
                | ({6'd0, b[7]} << (3'd6 - i_state.fill));

        grp[0]      = {1'b0, i_state.hdr};
        grp_full[0] = {1'b0, hdr_new};
        for (int i = 1; i < 8; i++) begin
            grp[i]      = {1'b0, i_state.store[i-1]};
            grp_full[i] = {1'b0, i_state.store[i-1]};
        end
        // the seventh byte of a full group is the one arriving now
        grp_full[7] = {1'b0, b[6:0]};

        flush_sum = 16'd0;
        full_sum  = 16'd0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < flush_n) begin
                flush_sum = flush_sum + 16'(grp[i]);
            end
            full_sum = full_sum + 16'(grp_full[i]);
        end

        tail[0] = {1'b0, i_state.sum[13:7]};
        tail[1] = {1'b0, i_state.sum[6:0]};
        tail[2] = {1'b0, len[13:7]};
        tail[3] = {1'b0, len[6:0]};
        tail[4] = SYSEX_END;

        o_step.n     = 4'd0;
        o_step.bytes = '0;
        o_step.next  = i_state;
        j            = 4'd0;

        unique case (cmd) inside
            CMD_DATA: begin
                if (!i_state.seven) begin
                    o_step.n        = 4'd1;
                    o_step.bytes[0] = b;
                    if (i_state.csum_on) begin
                        o_step.next.sum = i_state.sum + 16'(b);
                    end
                end else begin
                    o_step.next.hdr                  = hdr_new;
                    o_step.next.store[i_state.fill]  = b[6:0];
                    if (i_state.fill == 3'(GROUP_LEN - 1)) begin
                        o_step.n         = 4'd8;
                        o_step.next.fill = 3'd0;
                        for (int i = 0; i < 8; i++) begin
                            o_step.bytes[i] = grp_full[i];
                        end
                        if (i_state.csum_on) begin
                            o_step.next.sum = i_state.sum + full_sum;
                        end
                    end else begin
                        o_step.next.fill = i_state.fill + 3'd1;
                    end
                end
            end
            CMD_FLUSH, CMD_STOP7, CMD_RESET: begin
                o_step.n         = flush_n;
                o_step.next.fill = 3'd0;
                for (int i = 0; i < 8; i++) begin
                    o_step.bytes[i] = grp[i];
                end
                if (i_state.csum_on) begin
                    o_step.next.sum = i_state.sum + flush_sum;
                end
                if (cmd == CMD_STOP7) begin
                    o_step.next.seven = 1'b0;
                end else if (cmd == CMD_RESET) begin
                    o_step.next.seven = 1'b1;
                end
            end
            CMD_START7: begin
                o_step.next.seven = 1'b1;
                o_step.next.fill  = 3'd0;
            end
            CMD_CSUM_START: begin
                o_step.next.sum     = 16'd0;
                o_step.next.csum_on = 1'b1;
            end
            CMD_CSUM_END: begin
                // checksum stops before the flush, so flushed bytes stay out of the sum
                o_step.n            = flush_n + 4'(TAIL_LEN);
                o_step.next.csum_on = 1'b0;
                o_step.next.seven   = 1'b0;
                o_step.next.fill    = 3'd0;
                for (int i = 0; i < MAX_RESULTS; i++) begin
                    j = 4'(i) - flush_n;
                    if (4'(i) < flush_n) begin
                        o_step.bytes[i] = grp[i[2:0]];
                    end else if (j < 4'(TAIL_LEN)) begin
                        o_step.bytes[i] = tail[j[2:0]];
                    end
                end
            end
            default: begin
            end
        endcase

        o_step.next.count = i_state.count + 16'(o_step.n);
    end

endmodule

>>> design/sysex_seven_bit_packer_with_checksum_core.sv
// top level of the seven-bit sysex packer with running checksum
`timescale 1ns / 1ps

// Takes one command per transfer and produces 0 to 12 stream bytes per command,
// one output byte per cycle while the output is ready. A command is held in an input
// register, encoded combinationally and loaded into a burst register, and the burst
// drains through the output port. A new command is taken every cycle while the burst
// register is empty or on the cycle its last byte is transferred, so the sustained
// rate is set by the output port: a seven-bit group of 7 data bytes emits 8 bytes, raw
// mode emits one byte per data byte, and a checksum end emits up to 12. A command passes
// through the input register and then the burst register before its first byte is output.

module sysex_seven_bit_packer_with_checksum_core
    import ssp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_in                         r_in;
    logic                        r_in_vld;
    t_state                      r_state;
    logic [MAX_RESULTS-1:0][7:0] r_burst;
    logic [3:0]                  r_n;
    logic [3:0]                  r_idx;
    logic [15:0]                 r_base;

    t_step step;
    logic  out_take;
    logic  last_take;
    logic  move;

    ssp_step_logic u_step (
        .i_item  (r_in),
        .i_state (r_state),
        .o_step  (step)
    );

    assign o_out_valid = (r_n != 4'd0);
    assign out_take    = o_out_valid && i_out_ready;
    assign last_take   = out_take && (r_idx == r_n - 4'd1);
    assign move        = r_in_vld && ((r_n == 4'd0) || last_take);
    assign o_in_ready  = !r_in_vld || move;

    assign o_out_data.out_byte      = r_burst[r_idx];
    assign o_out_data.bytes_emitted = r_base + 16'(r_idx) + 16'd1;
    assign o_out_data.last          = (r_idx == r_n - 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.fill    <= 3'd0;
            r_state.seven   <= 1'b1;
            r_state.csum_on <= 1'b0;
            r_state.sum     <= 16'd0;
            r_state.count   <= 16'd0;
        end else if (move) begin
            r_state <= step.next;
        end
    end

    // burst register: loaded on a command move, drained one byte per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 4'd0;
        end else if (move) begin
            r_n <= step.n;
        end else if (last_take) begin
            r_n <= 4'd0;
        end
        if (move) begin
            r_idx   <= 4'd0;
            r_burst <= step.bytes;
            r_base  <= r_state.count;
        end else if (out_take) begin
            r_idx <= r_idx + 4'd1;
        end
    end

endmodule

>>> dv/sysex_seven_bit_packer_with_checksum_core_test.sv
// self-checking testbench for the seven-bit sysex packer with running checksum
`timescale 1ns / 1ps

module sysex_seven_bit_packer_with_checksum_core_test;
    import ssp_pkg::*;

    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    localparam int         RANDOM_ITEMS = 180;
    localparam int         CALM_FIRST   = 100;
    localparam int         CALM_LAST    = 160;
    localparam int         CYCLE_LIMIT  = 300000;

    // one stimulus row; typed rows carry their expected bytes written out by hand
    typedef struct packed {
        logic [2:0]      cmd;
        logic [7:0]      data;
        logic            typed;
        logic [2:0]      n_typed;
        logic [0:4][7:0] bytes_typed;
        logic [15:0]     cnt0;
    } t_stim_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in       i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out      o_out_data;

    t_stim_row cur_row     = '0;
    logic      calm        = 1'b0;
    int        mismatches  = 0;
    int        cycle_count = 0;

    t_stim_row directed_rows [27];
    t_stim_row cmd_stream [$];
    t_out      expected_stream [$];
    t_out      burst_q [$];

    // packer state as predicted
    logic [7:0]  grp_bytes [8];
    logic [2:0]  grp_fill;
    logic        seven_mode;
    logic        csum_active;
    logic [15:0] csum;
    logic [15:0] emit_cnt;

    sysex_seven_bit_packer_with_checksum_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_stim_row plain(input logic [2:0] c, input logic [7:0] d);
        t_stim_row r;
        r = '0;
        r.cmd  = c;
        r.data = d;
        return r;
    endfunction

    function automatic t_stim_row typed(input logic [2:0] c, input logic [7:0] d,
                                        input logic [2:0] n, input logic [15:0] cnt0,
                                        input logic [0:4][7:0] b);
        t_stim_row r;
        r = plain(c, d);
        r.typed       = 1'b1;
        r.n_typed     = n;
        r.bytes_typed = b;
        r.cnt0        = cnt0;
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        t_out r;
        emit_cnt = emit_cnt + 16'd1;
        if (csum_active) begin
            csum = csum + {8'd0, b};
        end
        r.out_byte      = b;
        r.bytes_emitted = emit_cnt;
        r.last          = 1'b0;
        burst_q.push_back(r);
    endtask

    task automatic flush_group();
        int n;
        n = (grp_fill > 0) ? int'(grp_fill) + 1 : 0;
        grp_fill = 3'd0;
        for (int i = 0; i < n; i++) send_byte(grp_bytes[i]);
    endtask

    // works out the bytes one command produces and advances the predicted state
    task automatic pack_command(input t_in it);
        int          k;
        logic [15:0] len;
        t_out        tail;
        burst_q.delete();
        case (it.command)
            CMD_DATA: begin
                if (!seven_mode) begin
                    send_byte(it.data_byte);
                end else begin
                    k = int'(grp_fill);
                    if (k == 0) begin
                        grp_bytes[0] = 8'd0;
                    end
                    grp_bytes[0][6 - k] = it.data_byte[7];
                    grp_bytes[k + 1]    = {1'b0, it.data_byte[6:0]};
                    k++;
                    if (k == GROUP_LEN) begin
                        grp_fill = 3'd0;
                        for (int i = 0; i < 8; i++) send_byte(grp_bytes[i]);
                    end else begin
                        grp_fill = 3'(k);
                    end
                end
            end
            CMD_FLUSH: flush_group();
            CMD_START7: begin
                seven_mode = 1'b1;
                grp_fill   = 3'd0;
            end
            CMD_STOP7: begin
                flush_group();
                seven_mode = 1'b0;
            end
            CMD_CSUM_START: begin
                csum        = 16'd0;
                csum_active = 1'b1;
            end
            CMD_CSUM_END: begin
                // length is taken before the flush adds to the count
                len         = emit_cnt - LEN_OFFSET;
                csum_active = 1'b0;
                flush_group();
                seven_mode = 1'b0;
                send_byte({1'b0, csum[13:7]});
                send_byte({1'b0, csum[6:0]});
                send_byte({1'b0, len[13:7]});
                send_byte({1'b0, len[6:0]});
                send_byte(SYSEX_END);
            end
            CMD_RESET: begin
                flush_group();
                seven_mode = 1'b1;
            end
            default: ;
        endcase
        if (burst_q.size() > 0) begin
            tail = burst_q.pop_back();
            tail.last = 1'b1;
            burst_q.push_back(tail);
        end
    endtask

    // prediction on input transfers, checking on output transfers
    always @(posedge i_clk) begin
        t_out got;
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = o_out_data;
                if (expected_stream.size() == 0) begin
                    $display("%0t: unexpected output byte %h count %0d last %b",
                             $time, got.out_byte, got.bytes_emitted, got.last);
                    mismatches++;
                end else begin
                    want = expected_stream.pop_front();
                    if (got.out_byte !== want.out_byte
                        || got.bytes_emitted !== want.bytes_emitted
                        || got.last !== want.last) begin
                        $display("%0t: expected byte %h count %0d last %b, got %h %0d %b",
                                 $time, want.out_byte, want.bytes_emitted, want.last,
                                 got.out_byte, got.bytes_emitted, got.last);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                pack_command(i_in_data);
                if (cur_row.typed) begin
                    for (int i = 0; i < int'(cur_row.n_typed); i++) begin
                        want.out_byte      = cur_row.bytes_typed[i];
                        want.bytes_emitted = cur_row.cnt0 + 16'(i);
                        want.last          = (i == int'(cur_row.n_typed) - 1);
                        expected_stream.push_back(want);
                    end
                end else begin
                    foreach (burst_q[i]) expected_stream.push_back(burst_q[i]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(99) >= 23);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL sysex_seven_bit_packer_with_checksum_core");
            $finish;
        end
    end

    initial begin
        int        real_items;
        int        len;
        int        pick;
        t_stim_row row;

        foreach (grp_bytes[i]) grp_bytes[i] = 8'd0;
        grp_fill    = 3'd0;
        seven_mode  = 1'b1;
        csum_active = 1'b0;
        csum        = 16'd0;
        emit_cnt    = 16'd0;

        // checksum end straight after reset: zero sum, length wraps below zero
        directed_rows[0]  = typed(CMD_CSUM_END, 8'h00, 3'd5, 16'd1,
                                  {8'h00, 8'h00, 8'h7F, 8'h7B, SYSEX_END});
        directed_rows[1]  = typed(CMD_FLUSH, 8'hFF, 3'd0, 16'd0, '0);
        directed_rows[2]  = typed(CMD_DATA, 8'hFF, 3'd1, 16'd6, {8'hFF, 32'd0});
        directed_rows[3]  = typed(CMD_UNUSED, 8'h5A, 3'd0, 16'd0, '0);
        directed_rows[4]  = typed(CMD_START7, 8'hA5, 3'd0, 16'd0, '0);
        directed_rows[5]  = typed(CMD_CSUM_START, 8'h00, 3'd0, 16'd0, '0);
        directed_rows[6]  = plain(CMD_DATA, 8'hFF);
        directed_rows[7]  = plain(CMD_DATA, 8'h80);
        directed_rows[8]  = plain(CMD_DATA, 8'h7F);
        directed_rows[9]  = plain(CMD_DATA, 8'h00);
        directed_rows[10] = plain(CMD_DATA, 8'hAA);
        directed_rows[11] = plain(CMD_DATA, 8'h55);
        directed_rows[12] = plain(CMD_DATA, 8'h01);
        directed_rows[13] = plain(CMD_DATA, 8'h80);
        directed_rows[14] = plain(CMD_FLUSH, 8'h00);
        directed_rows[15] = plain(CMD_DATA, 8'hC3);
        directed_rows[16] = plain(CMD_STOP7, 8'h00);
        directed_rows[17] = typed(CMD_RESET, 8'h00, 3'd0, 16'd0, '0);
        directed_rows[18] = plain(CMD_DATA, 8'h81);
        // partial group dropped without output
        directed_rows[19] = typed(CMD_START7, 8'h00, 3'd0, 16'd0, '0);
        directed_rows[20] = plain(CMD_DATA, 8'h3F);
        directed_rows[21] = plain(CMD_DATA, 8'hC0);
        directed_rows[22] = plain(CMD_DATA, 8'hFE);
        directed_rows[23] = plain(CMD_DATA, 8'h01);
        directed_rows[24] = plain(CMD_DATA, 8'h7E);
        directed_rows[25] = plain(CMD_DATA, 8'h80);
        // six pending bytes plus the tail: the longest burst
        directed_rows[26] = plain(CMD_CSUM_END, 8'h00);
        foreach (directed_rows[i]) cmd_stream.push_back(directed_rows[i]);

        // mostly whole checksummed messages, the rest loose commands
        real_items = 0;
        while (real_items < RANDOM_ITEMS) begin
            if ($urandom_range(99) < 80) begin
                cmd_stream.push_back(plain(CMD_CSUM_START, 8'($urandom_range(255))));
                if ($urandom_range(1) == 1) begin
                    cmd_stream.push_back(plain(CMD_START7, 8'($urandom_range(255))));
                end else if ($urandom_range(3) == 0) begin
                    cmd_stream.push_back(plain(CMD_STOP7, 8'($urandom_range(255))));
                end
                len = $urandom_range(24);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(11) == 0) begin
                        pick = $urandom_range(4);
                        case (pick)
                            0: row = plain(CMD_FLUSH, 8'($urandom_range(255)));
                            1: row = plain(CMD_RESET, 8'($urandom_range(255)));
                            2: row = plain(CMD_START7, 8'($urandom_range(255)));
                            3: row = plain(CMD_STOP7, 8'($urandom_range(255)));
                            default: row = plain(CMD_UNUSED, 8'($urandom_range(255)));
                        endcase
                    end else begin
                        row = plain(CMD_DATA, 8'($urandom_range(255)));
                    end
                    cmd_stream.push_back(row);
                end
                if ($urandom_range(9) == 0) begin
                    cmd_stream.push_back(plain(CMD_RESET, 8'($urandom_range(255))));
                end else begin
                    cmd_stream.push_back(plain(CMD_CSUM_END, 8'($urandom_range(255))));
                end
                real_items += len + 3;
            end else begin
                cmd_stream.push_back(plain(3'($urandom_range(7)), 8'($urandom_range(255))));
                real_items++;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (cmd_stream[idx]) begin
            calm <= (idx >= CALM_FIRST && idx < CALM_LAST);
            while (!(idx >= CALM_FIRST && idx < CALM_LAST) && $urandom_range(99) < 23) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= '{command: cmd_stream[idx].cmd, data_byte: cmd_stream[idx].data};
            cur_row    <= cmd_stream[idx];
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
        end
        i_in_valid <= 1'b0;
        calm       <= 1'b0;

        while (expected_stream.size() != 0) @(posedge i_clk);
        // a late stray byte would still be caught here
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS sysex_seven_bit_packer_with_checksum_core");
        end else begin
            $display("FAIL sysex_seven_bit_packer_with_checksum_core");
        end
        $finish;
    end

endmodule

>>> sysex_seven_bit_packer_with_checksum_core.f
design/ssp_pkg.sv
design/ssp_step_logic.sv
design/sysex_seven_bit_packer_with_checksum_core.sv
dv/sysex_seven_bit_packer_with_checksum_core_test.sv
